/* hdl/spc_pkg.sv */
// Package for the PID speed controller: payload structs, register indexes,
// controller states, datapath command/status structs and fixed-point helpers.
// No dependencies.
package spc_pkg;

  // Configuration register indexes, in register-map order.
  typedef enum logic [2:0] {
    CFG_GAIN_P          = 3'd0,
    CFG_GAIN_I          = 3'd1,
    CFG_GAIN_D          = 3'd2,
    CFG_ERROR_SUM_LIMIT = 3'd3,
    CFG_DRIVE_MIN       = 3'd4,
    CFG_DRIVE_MAX       = 3'd5,
    CFG_SAMPLE_PERIOD   = 3'd6,
    CFG_SPEED_SCALE     = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 3;

  // Two pi in Q16.16.
  localparam logic signed [32:0] TwoPiQ16 = 33'sd411775;

  // Reset value of the speed scale: 1.0 in Q16.16.
  localparam logic [30:0] SpeedScaleRst = 31'd65536;

  // Saturation bounds for the 66-bit product domain.
  localparam logic signed [65:0] Sat32Max = 66'sd2147483647;
  localparam logic signed [65:0] Sat32Min = -66'sd2147483648;

  // Rounding offset for Q32.32 to Q16.16.
  localparam logic signed [65:0] RoundHalf = 66'sd32768;

  typedef struct packed {
    logic               operation;
    logic        [31:0] now_ms;
    logic signed [31:0] target_speed;
    logic signed [15:0] pulse_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] measured_speed;
    logic signed [31:0] drive;
  } out_item_t;

  // Item operation codes.
  localparam logic OpSample = 1'b0;
  localparam logic OpClear  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SPEED,
    ST_SAT_SPEED,
    ST_MUL_ERR,
    ST_RND_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_DONE
  } state_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_SPEED,
    MUL_ERR,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_e;

  typedef struct packed {
    logic     capture;
    logic     clear;
    logic     prod_en;
    mul_sel_e mul_sel;
    logic     load_speed;
    logic     load_err;
    logic     load_diff;
    logic     acc_init;
    logic     acc_add;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic too_early;
  } dp_status_t;

  // Saturate a signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > Sat32Max) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Sat32Min) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round a Q32.32 product to Q16.16: add one half, then floor shift by 16.
  function automatic logic signed [49:0] round_q16(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + RoundHalf;
    return $signed(t[65:16]);
  endfunction

endpackage

/* hdl/spc_ctrl.sv */
// Controller state machine of the PID speed controller.
// Sequences the datapath through the product chain and owns both handshakes.
// Depends on spc_pkg.
module spc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  spc_pkg::dp_status_t status_i,
  output spc_pkg::dp_cmd_t    cmd_o
);

  spc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            in_fire;

  assign in_ready_o  = (state_q == spc_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = spc_pkg::MUL_SPEED;
    unique case (state_q)
      spc_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_o.capture = 1'b1;
          if (status_i.op_clear) begin
            cmd_o.clear = 1'b1;
          end else if (!status_i.too_early) begin
            state_d = spc_pkg::ST_MUL_SPEED;
          end
        end
      end
      spc_pkg::ST_MUL_SPEED: begin
        cmd_o.prod_en = 1'b1;
        cmd_o.mul_sel = spc_pkg::MUL_SPEED;
        state_d       = spc_pkg::ST_SAT_SPEED;
      end
      spc_pkg::ST_SAT_SPEED: begin
        cmd_o.load_speed = 1'b1;
        state_d          = spc_pkg::ST_MUL_ERR;
      end
      spc_pkg::ST_MUL_ERR: begin
        cmd_o.prod_en = 1'b1;
        cmd_o.mul_sel = spc_pkg::MUL_ERR;
        state_d       = spc_pkg::ST_RND_ERR;
      end
      spc_pkg::ST_RND_ERR: begin
        cmd_o.load_err = 1'b1;
        state_d        = spc_pkg::ST_MUL_P;
      end
      spc_pkg::ST_MUL_P: begin
        cmd_o.prod_en   = 1'b1;
        cmd_o.mul_sel   = spc_pkg::MUL_P;
        cmd_o.load_diff = 1'b1;
        state_d         = spc_pkg::ST_MUL_I;
      end
      spc_pkg::ST_MUL_I: begin
        cmd_o.prod_en  = 1'b1;
        cmd_o.mul_sel  = spc_pkg::MUL_I;
        cmd_o.acc_init = 1'b1;
        state_d        = spc_pkg::ST_MUL_D;
      end
      spc_pkg::ST_MUL_D: begin
        cmd_o.prod_en = 1'b1;
        cmd_o.mul_sel = spc_pkg::MUL_D;
        cmd_o.acc_add = 1'b1;
        state_d       = spc_pkg::ST_ACC;
      end
      spc_pkg::ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = spc_pkg::ST_DONE;
      end
      spc_pkg::ST_DONE: begin
        // Load the result only when the output register is free or emptying.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = spc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spc_pkg::ST_IDLE;
      end
    endcase
  end

  // The output register holds one result until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  // A committed result is never written over a result that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over a pending result");

  // A commit always presents a result in the next cycle.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not presented");

  // A sample transaction that is due starts the product chain.
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !status_i.op_clear && !status_i.too_early)
      |=> (state_q == spc_pkg::ST_MUL_SPEED))
    else $error("due sample did not start the computation");

  // Clear and early transactions leave the controller idle.
  a_skip_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (status_i.op_clear || status_i.too_early))
      |=> (state_q == spc_pkg::ST_IDLE))
    else $error("skipped transaction left idle");

endmodule

/* hdl/spc_datapath.sv */
// Datapath of the PID speed controller: configuration registers, loop state,
// one shared 33x33 signed multiplier, rounding, saturation and clamping.
// Depends on spc_pkg.
module spc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [spc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  spc_pkg::in_item_t               in_data_i,
  input  spc_pkg::dp_cmd_t                cmd_i,
  output spc_pkg::dp_status_t             status_o,
  output spc_pkg::out_item_t              out_data_o
);

  // Configuration registers.
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic        [30:0] sum_limit_q;
  logic signed [31:0] drive_min_q, drive_max_q;
  logic        [15:0] period_q;
  logic        [30:0] scale_q;

  // Loop state.
  logic        [31:0] last_q;
  logic signed [31:0] sum_q, prev_q;

  // Working registers.
  spc_pkg::in_item_t  in_q;
  logic signed [31:0] speed_q, err_q, diff_q;
  logic signed [32:0] delta_q;
  logic signed [65:0] prod_q;
  logic signed [49:0] acc_q;
  spc_pkg::out_item_t out_q;

  // Combinational terms.
  logic        [31:0] elapsed;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_w;
  logic signed [31:0] speed_sat;
  logic signed [32:0] delta_w;
  logic signed [49:0] prod_rnd;
  logic signed [31:0] err_sat;
  logic signed [32:0] diff_w;
  logic signed [31:0] diff_sat;
  logic signed [49:0] drive_max_x, drive_min_x, acc_hi;
  logic signed [31:0] drive_w;
  logic signed [33:0] sum_raw, lim_pos, lim_neg;
  logic signed [31:0] sum_next;

  // Configuration writes; every index of the port maps to a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      sum_limit_q <= '0;
      drive_min_q <= '0;
      drive_max_q <= '0;
      period_q    <= '0;
      scale_q     <= spc_pkg::SpeedScaleRst;
    end else if (cfg_valid_i) begin
      unique case (spc_pkg::cfg_idx_e'(cfg_index_i))
        spc_pkg::CFG_GAIN_P:          gain_p_q    <= $signed(cfg_data_i);
        spc_pkg::CFG_GAIN_I:          gain_i_q    <= $signed(cfg_data_i);
        spc_pkg::CFG_GAIN_D:          gain_d_q    <= $signed(cfg_data_i);
        spc_pkg::CFG_ERROR_SUM_LIMIT: sum_limit_q <= cfg_data_i[30:0];
        spc_pkg::CFG_DRIVE_MIN:       drive_min_q <= $signed(cfg_data_i);
        spc_pkg::CFG_DRIVE_MAX:       drive_max_q <= $signed(cfg_data_i);
        spc_pkg::CFG_SAMPLE_PERIOD:   period_q    <= cfg_data_i[15:0];
        spc_pkg::CFG_SPEED_SCALE:     scale_q     <= cfg_data_i[30:0];
        default:                      period_q    <= period_q;
      endcase
    end
  end

  // Sample timing check, modulo 2^32.
  assign elapsed            = in_data_i.now_ms - last_q;
  assign status_o.too_early = (elapsed < {16'd0, period_q});
  assign status_o.op_clear  = (in_data_i.operation == spc_pkg::OpClear);

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd_i.mul_sel)
      spc_pkg::MUL_SPEED: begin
        mul_a = {{17{in_q.pulse_count[15]}}, in_q.pulse_count};
        mul_b = {2'b00, scale_q};
      end
      spc_pkg::MUL_ERR: begin
        mul_a = delta_q;
        mul_b = spc_pkg::TwoPiQ16;
      end
      spc_pkg::MUL_P: begin
        mul_a = {gain_p_q[31], gain_p_q};
        mul_b = {err_q[31], err_q};
      end
      spc_pkg::MUL_I: begin
        mul_a = {gain_i_q[31], gain_i_q};
        mul_b = {sum_q[31], sum_q};
      end
      spc_pkg::MUL_D: begin
        mul_a = {gain_d_q[31], gain_d_q};
        mul_b = {diff_q[31], diff_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // Speed saturation and the setpoint difference.
  assign speed_sat = spc_pkg::sat32(prod_q);
  assign delta_w   = {in_q.target_speed[31], in_q.target_speed} - {speed_sat[31], speed_sat};

  // Rounded product, error saturation and derivative difference.
  assign prod_rnd = spc_pkg::round_q16(prod_q);
  assign err_sat  = spc_pkg::sat32({{16{prod_rnd[49]}}, prod_rnd});
  assign diff_w   = {err_q[31], err_q} - {prev_q[31], prev_q};
  assign diff_sat = spc_pkg::sat32({{33{diff_w[32]}}, diff_w});

  // Drive clamp: the lower bound wins when the bounds are inverted.
  assign drive_max_x = {{18{drive_max_q[31]}}, drive_max_q};
  assign drive_min_x = {{18{drive_min_q[31]}}, drive_min_q};
  assign acc_hi      = (acc_q > drive_max_x) ? drive_max_x : acc_q;
  assign drive_w     = (acc_hi < drive_min_x) ? drive_min_q : acc_hi[31:0];

  // Error sum update with symmetric clamp.
  assign sum_raw = {{2{sum_q[31]}}, sum_q} + {{2{err_q[31]}}, err_q};
  assign lim_pos = {3'b000, sum_limit_q};
  assign lim_neg = -lim_pos;
  always_comb begin
    if (sum_raw > lim_pos) begin
      sum_next = lim_pos[31:0];
    end else if (sum_raw < lim_neg) begin
      sum_next = lim_neg[31:0];
    end else begin
      sum_next = sum_raw[31:0];
    end
  end

  // Loop state: error sum and previous error cleared by a clear transaction, all advanced by each result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      sum_q  <= '0;
      prev_q <= '0;
    end else if (cmd_i.clear) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (cmd_i.commit) begin
      last_q <= in_q.now_ms;
      sum_q  <= sum_next;
      prev_q <= err_q;
    end
  end

  // Working and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.prod_en) begin
      prod_q <= prod_w;
    end
    if (cmd_i.load_speed) begin
      speed_q <= speed_sat;
      delta_q <= delta_w;
    end
    if (cmd_i.load_err) begin
      err_q <= err_sat;
    end
    if (cmd_i.load_diff) begin
      diff_q <= diff_sat;
    end
    if (cmd_i.acc_init) begin
      acc_q <= prod_rnd;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_rnd;
    end
    if (cmd_i.commit) begin
      out_q.measured_speed <= speed_q;
      out_q.drive          <= drive_w;
    end
  end

  assign out_data_o = out_q;

  // A clear leaves both loop terms at zero.
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (sum_q == '0) && (prev_q == '0))
    else $error("clear did not zero the loop state");

  // With ordered bounds the committed drive lies inside them.
  a_drive_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (drive_min_q <= drive_max_q))
      |=> (out_q.drive >= $past(drive_min_q)) && (out_q.drive <= $past(drive_max_q)))
    else $error("drive outside its bounds");

endmodule

/* hdl/pid_speed_controller_unit.sv */
// Top level of the PID speed controller with integral clamp (Q16.16).
// Instantiates spc_ctrl and spc_datapath; depends on spc_pkg.
//
// Usage:
//   in channel   (in_valid_i/in_ready_o, in_data_i): one item per transaction,
//                either a sample attempt or a clear of the error sum and the
//                previous error.
//   out channel  (out_valid_o/out_ready_i, out_data_o): measured speed and
//                drive, one result for each sample that is due; clear items
//                and samples that arrive before the sample period has passed
//                give no result.
//   cfg channel  (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): register
//                writes, always ready; write only while the block is idle.
// Operation: a due sample passes through nine controller states built around one
// shared 33x33 multiplier that forms five chained products; a new item is
// accepted only once the result of the previous one is committed. Clear and
// early items are accepted in the idle state and leave the controller idle.
// Reset sets the configuration registers to their reset values (speed scale
// 1.0) and the loop state to zero. A stalled receiver holds the result in the
// output register; the next item is still accepted and is computed, then waits
// in the final state until the output register frees up.
module pid_speed_controller_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  spc_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output spc_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [spc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  spc_pkg::dp_cmd_t    cmd;
  spc_pkg::dp_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  spc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/pid_speed_controller_unit_checker.sv */
// Checker for the PID speed controller: watches the config, input and result channels,
// predicts each result in Q16.16 and compares it with what the block emits.
// Depends on spc_pkg for the payload structs and register indexes.
`timescale 1ns / 1ps

module pid_speed_controller_unit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  spc_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  spc_pkg::out_item_t           out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [spc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam longint TwoPiFixed = 64'sd411775;

  // Shadow copy of the register file.
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic        [30:0] sum_limit;
  logic signed [31:0] drive_lo;
  logic signed [31:0] drive_hi;
  logic        [15:0] sample_period;
  logic        [30:0] speed_scale;

  // Shadow copy of the loop state.
  logic        [31:0] last_compute_ms;
  logic signed [31:0] error_sum;
  logic signed [31:0] prev_error;

  spc_pkg::out_item_t drive_results_q[$];
  int unsigned        mismatch_count;

  // Saturate a wide value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Round a Q32.32 product to Q16.16: add one half, then floor.
  function automatic longint round_to_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic void write_register(input spc_pkg::cfg_idx_e idx,
                                         input logic [31:0] data);
    case (idx)
      spc_pkg::CFG_GAIN_P:          gain_p = data;
      spc_pkg::CFG_GAIN_I:          gain_i = data;
      spc_pkg::CFG_GAIN_D:          gain_d = data;
      spc_pkg::CFG_ERROR_SUM_LIMIT: sum_limit = data[30:0];
      spc_pkg::CFG_DRIVE_MIN:       drive_lo = data;
      spc_pkg::CFG_DRIVE_MAX:       drive_hi = data;
      spc_pkg::CFG_SAMPLE_PERIOD:   sample_period = data[15:0];
      spc_pkg::CFG_SPEED_SCALE:     speed_scale = data[30:0];
      default: ;
    endcase
  endfunction

  // One control step: update the loop state and queue the result, if any.
  function automatic void apply_control_step(input spc_pkg::in_item_t item);
    logic        [31:0] elapsed;
    logic signed [31:0] speed_q;
    logic signed [31:0] error_q;
    logic signed [31:0] delta_q;
    longint             drive_acc;
    longint             sum_acc;
    longint             limit;
    spc_pkg::out_item_t result;
    if (item.operation == spc_pkg::OpClear) begin
      error_sum  = '0;
      prev_error = '0;
      return;
    end
    elapsed = item.now_ms - last_compute_ms;
    if (elapsed < {16'd0, sample_period}) begin
      return;
    end

    speed_q = clamp_s32(longint'($signed(item.pulse_count)) * longint'({1'b0, speed_scale}));
    error_q = clamp_s32(round_to_q16((longint'($signed(item.target_speed)) -
                                      longint'(speed_q)) * TwoPiFixed));
    delta_q = clamp_s32(longint'(error_q) - longint'(prev_error));

    drive_acc = round_to_q16(longint'(gain_p) * longint'(error_q)) +
                round_to_q16(longint'(gain_i) * longint'(error_sum)) +
                round_to_q16(longint'(gain_d) * longint'(delta_q));
    // The lower bound wins when the bounds are inverted.
    if (drive_acc > longint'(drive_hi)) begin
      drive_acc = longint'(drive_hi);
    end
    if (drive_acc < longint'(drive_lo)) begin
      drive_acc = longint'(drive_lo);
    end

    // Integrate with a symmetric clamp.
    limit   = longint'({1'b0, sum_limit});
    sum_acc = longint'(error_sum) + longint'(error_q);
    if (sum_acc > limit) begin
      sum_acc = limit;
    end
    if (sum_acc < -limit) begin
      sum_acc = -limit;
    end
    prev_error      = error_q;
    error_sum       = sum_acc[31:0];
    last_compute_ms = item.now_ms;

    result.measured_speed = speed_q;
    result.drive          = drive_acc[31:0];
    drive_results_q.push_back(result);
  endfunction

  function automatic void check_drive_result(input spc_pkg::out_item_t actual);
    spc_pkg::out_item_t expected;
    if (drive_results_q.size() == 0) begin
      mismatch_count++;
      $error("unexpected result: measured_speed %0d, drive %0d",
             actual.measured_speed, actual.drive);
      return;
    end
    expected = drive_results_q.pop_front();
    if (actual.measured_speed !== expected.measured_speed) begin
      mismatch_count++;
      $error("measured_speed mismatch: expected %0d, actual %0d",
             expected.measured_speed, actual.measured_speed);
    end
    if (actual.drive !== expected.drive) begin
      mismatch_count++;
      $error("drive mismatch: expected %0d, actual %0d", expected.drive, actual.drive);
    end
  endfunction

  // Follow every transaction in the order config, input, result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p          = '0;
      gain_i          = '0;
      gain_d          = '0;
      sum_limit       = '0;
      drive_lo        = '0;
      drive_hi        = '0;
      sample_period   = '0;
      speed_scale     = spc_pkg::SpeedScaleRst;
      last_compute_ms = '0;
      error_sum       = '0;
      prev_error      = '0;
      mismatch_count  = 0;
      drive_results_q.delete();
      fail_count_o   <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        write_register(spc_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        apply_control_step(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_drive_result(out_data_i);
      end
      fail_count_o <= mismatch_count;
      pending_o    <= drive_results_q.size();
    end
  end

endmodule

/* tb/pid_speed_controller_unit_tb.sv */
// Testbench top for the PID speed controller: drives config writes and input items
// with bursts, gaps and receiver stalls, and reports the verdict of the checker.
// Depends on spc_pkg, pid_speed_controller_unit and pid_speed_controller_unit_checker.
`timescale 1ns / 1ps

module pid_speed_controller_unit_tb;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  spc_pkg::in_item_t           in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  spc_pkg::out_item_t          out_data_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [spc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]                 cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending_results;
  int          burst_left  = 0;
  int          cur_period  = 0;
  int          stall_mode  = 0;
  int          mode_left   = 0;
  int          stall_phase = 0;

  pid_speed_controller_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pid_speed_controller_unit_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver readiness: modes of random length, from always ready to long stalls.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (stall_phase % 5 == 0);
      default: out_ready_i <= ($urandom_range(0, 23) == 0);
    endcase
  end

  function automatic spc_pkg::in_item_t make_item(input logic op, input logic [31:0] stamp,
                                                  input logic [31:0] target,
                                                  input logic [15:0] pulses);
    spc_pkg::in_item_t item;
    item.operation    = op;
    item.now_ms       = stamp;
    item.target_speed = target;
    item.pulse_count  = pulses;
    return item;
  endfunction

  // Present one item, wait for its transaction, then keep bursting or leave a gap.
  task automatic send_item(input spc_pkg::in_item_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every result has come and the block has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input spc_pkg::cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_registers(input logic [31:0] gp, input logic [31:0] gi,
                                input logic [31:0] gd, input logic [31:0] lim,
                                input logic [31:0] dmin, input logic [31:0] dmax,
                                input logic [31:0] per, input logic [31:0] scl);
    write_reg(spc_pkg::CFG_GAIN_P, gp);
    write_reg(spc_pkg::CFG_GAIN_I, gi);
    write_reg(spc_pkg::CFG_GAIN_D, gd);
    write_reg(spc_pkg::CFG_ERROR_SUM_LIMIT, lim);
    write_reg(spc_pkg::CFG_DRIVE_MIN, dmin);
    write_reg(spc_pkg::CFG_DRIVE_MAX, dmax);
    write_reg(spc_pkg::CFG_SAMPLE_PERIOD, per);
    write_reg(spc_pkg::CFG_SPEED_SCALE, scl);
    cfg_valid_i <= 1'b0;
    cur_period = int'(per[15:0]);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1 << 19) - (1 << 18);
      2:       return 32'h0;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Random register set; unused upper bits of narrow registers get random values.
  task automatic random_config();
    logic [31:0] lim;
    logic [31:0] dlo;
    logic [31:0] dhi;
    logic [31:0] per;
    logic [31:0] scl;
    logic [31:0] a;
    logic [31:0] b;
    case ($urandom_range(0, 3))
      0:       lim = $urandom;
      1:       lim = $urandom_range(0, 1 << 24);
      2:       lim = $urandom & 32'h8000_0000;
      default: lim = 32'h7FFF_FFFF | ($urandom & 32'h8000_0000);
    endcase
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        dlo = 32'h8000_0000;
        dhi = 32'h7FFF_FFFF;
      end
      1: begin
        dlo = ($signed(a) <= $signed(b)) ? a : b;
        dhi = ($signed(a) <= $signed(b)) ? b : a;
      end
      2: begin
        dlo = ($signed(a) <= $signed(b)) ? b : a;
        dhi = ($signed(a) <= $signed(b)) ? a : b;
      end
      default: begin
        a   = $urandom_range(1, 1 << 24);
        dlo = -a;
        dhi = a;
      end
    endcase
    case ($urandom_range(0, 8))
      0, 1, 2, 3, 4, 5: per = $urandom_range(1, 20);
      6:                per = 0;
      7:                per = 32'hFFFF;
      default:          per = $urandom_range(0, 65535);
    endcase
    per = per | ($urandom & 32'hFFFF_0000);
    case ($urandom_range(0, 3))
      0:       scl = $urandom_range(0, 1 << 20);
      1:       scl = $urandom;
      2:       scl = 32'h7FFF_FFFF;
      default: scl = 32'h0001_0000 | ($urandom & 32'h8000_0000);
    endcase
    load_registers(pick_gain(), pick_gain(), pick_gain(), lim, dlo, dhi, per, scl);
  endtask

  // Mostly due samples with random content, some early ones, jumps and clears.
  task automatic random_traffic(input int count);
    logic [31:0] now_ms;
    logic [31:0] target;
    logic [15:0] pulses;
    now_ms = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(make_item(spc_pkg::OpClear, $urandom, $urandom, 16'($urandom)));
      end else begin
        case ($urandom_range(0, 9))
          0:       now_ms += $urandom;
          1, 2:    now_ms += $urandom_range(0, cur_period);
          default: now_ms += cur_period + $urandom_range(0, cur_period / 2 + 3);
        endcase
        if ($urandom_range(0, 2) == 0) begin
          target = $urandom;
        end else begin
          target = $urandom_range(0, 1 << 21) - (1 << 20);
        end
        if ($urandom_range(0, 2) == 0) begin
          pulses = 16'($urandom);
        end else begin
          pulses = 16'($urandom_range(0, 400) - 200);
        end
        send_item(make_item(spc_pkg::OpSample, now_ms, target, pulses));
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: zero period, so every sample computes.
    send_item(make_item(spc_pkg::OpSample, 32'd0, 32'h0001_0000, 16'd3));
    send_item(make_item(spc_pkg::OpSample, 32'd1, 32'hFFFE_0000, 16'hFFFC));
    wait_idle();

    // Moderate gains, full drive range, 10 ms period.
    load_registers(32'h0001_0000, 32'h0000_4000, 32'hFFFF_8000, 32'h0064_0000,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'd10, 32'h0001_0000);
    send_item(make_item(spc_pkg::OpSample, 32'd100, 32'h7FFF_FFFF, 16'h8000));
    send_item(make_item(spc_pkg::OpSample, 32'd105, 32'h0001_0000, 16'd1));
    send_item(make_item(spc_pkg::OpSample, 32'd110, 32'h8000_0000, 16'h7FFF));
    send_item(make_item(spc_pkg::OpClear, $urandom, $urandom, 16'($urandom)));
    send_item(make_item(spc_pkg::OpSample, 32'd120, 32'h0, 16'h0));
    // Time stamp wraps around zero between these samples.
    send_item(make_item(spc_pkg::OpSample, 32'hFFFF_FFF8, 32'h0001_8000, 16'd3));
    send_item(make_item(spc_pkg::OpSample, 32'd2, 32'hFFFE_0000, 16'hFFFB));
    send_item(make_item(spc_pkg::OpSample, 32'd11, 32'h0003_0000, 16'd2));
    send_item(make_item(spc_pkg::OpSample, 32'd12, $urandom, 16'($urandom)));
    wait_idle();

    // Extreme gains and scale, inverted drive bounds, zero period.
    load_registers(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h0005_0000, 32'hFFFB_0000, 32'h0, 32'hFFFF_FFFF);
    send_item(make_item(spc_pkg::OpSample, $urandom, 32'h0, 16'd1));
    send_item(make_item(spc_pkg::OpSample, $urandom, 32'h8000_0000, 16'h7FFF));
    send_item(make_item(spc_pkg::OpSample, $urandom, 32'h7FFF_FFFF, 16'h8000));
    send_item(make_item(spc_pkg::OpSample, $urandom, 32'h0, 16'h0));
    send_item(make_item(spc_pkg::OpClear, $urandom, $urandom, 16'($urandom)));
    wait_idle();

    // Longest period, zero scale, no integral range.
    load_registers(32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'h0);
    send_item(make_item(spc_pkg::OpSample, 32'd1000, 32'h0001_0000, 16'd7));
    send_item(make_item(spc_pkg::OpSample, 32'd66534, 32'h0002_0000, 16'd7));
    send_item(make_item(spc_pkg::OpSample, 32'd66535, 32'hFFFF_0000, 16'd7));
    send_item(make_item(spc_pkg::OpSample, 32'h8000_0000, $urandom, 16'($urandom)));

    for (int phase = 0; phase < 7; phase++) begin
      wait_idle();
      random_config();
      random_traffic(170);
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
